// ===== hdl/jasr_pkg.sv =====
package jasr_pkg;

    localparam int AXIS_FULL_SCALE = 32767;

    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 21;

    // register indexes
    localparam logic [W_CFG_IDX-1:0] REG_RAW_MODE         = 3'd0;
    localparam logic [W_CFG_IDX-1:0] REG_ANGLE_LIMIT      = 3'd1;
    localparam logic [W_CFG_IDX-1:0] REG_SLIDE_NEUTRAL    = 3'd2;
    localparam logic [W_CFG_IDX-1:0] REG_SLIDE_PULL_LIMIT = 3'd3;
    localparam logic [W_CFG_IDX-1:0] REG_SLIDE_PUSH_LIMIT = 3'd4;
    localparam logic [W_CFG_IDX-1:0] REG_ANGLE_STEP_LIMIT = 3'd5;
    localparam logic [W_CFG_IDX-1:0] REG_SLIDE_STEP_LIMIT = 3'd6;
    localparam logic [W_CFG_IDX-1:0] REG_DEAD_BAND        = 3'd7;

    // reset values
    localparam logic [20:0]        RST_ANGLE_LIMIT      = 21'd872665;
    localparam logic signed [18:0] RST_SLIDE_NEUTRAL    = -19'sd80000;
    localparam logic signed [18:0] RST_SLIDE_PULL_LIMIT = -19'sd159000;
    localparam logic signed [18:0] RST_SLIDE_PUSH_LIMIT = -19'sd1000;
    localparam logic [17:0]        RST_ANGLE_STEP_LIMIT = 18'd30000;
    localparam logic [13:0]        RST_SLIDE_STEP_LIMIT = 14'd800;
    localparam logic [14:0]        RST_DEAD_BAND        = 15'd1638;

    // quotient bits of the scaling divide
    localparam int DIV_STEPS = 21;

    typedef struct packed {
        logic latch;
        logic avg;
        logic prep;
        logic axis;
        logic mul;
        logic div;
        logic tgt;
        logic step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic new_knot;
        logic connected;
        logic div_done;
    } t_sts;

endpackage

// ===== hdl/jasr_in_if.sv =====
interface jasr_in_if;
    logic               valid;
    logic               ready;
    logic               new_knot;
    logic               connected;
    logic signed [15:0] angle_axis;
    logic signed [15:0] slide_axis;
    logic [7:0]         phase_frac;

    modport source (output valid, new_knot, connected, angle_axis, slide_axis, phase_frac,
                    input ready);
    modport sink   (input valid, new_knot, connected, angle_axis, slide_axis, phase_frac,
                    output ready);
endinterface

// ===== hdl/jasr_out_if.sv =====
interface jasr_out_if;
    logic               valid;
    logic               ready;
    logic signed [21:0] angle_ref;
    logic signed [18:0] slide_ref;
    logic signed [22:0] angle_step;
    logic signed [18:0] slide_step;

    modport source (output valid, angle_ref, slide_ref, angle_step, slide_step, input ready);
    modport sink   (input valid, angle_ref, slide_ref, angle_step, slide_step, output ready);
endinterface

// ===== hdl/jasr_ctrl.sv =====
module jasr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  jasr_pkg::t_sts  i_sts,
    output jasr_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AVG  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_TGT  = 3'd5;
    localparam logic [2:0] S_STEP = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_axis, n_axis;
    logic       r_ov, n_ov;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = i_sts.new_knot ? S_AVG : S_OUT;
                end
            end
            S_AVG: begin
                o_cmd.avg = 1'b1;
                n_axis  = 1'b0;
                n_state = i_sts.connected ? S_PREP : S_STEP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_TGT;
                end else begin
                    o_cmd.div = 1'b1;
                end
            end
            S_TGT: begin
                o_cmd.tgt = 1'b1;
                if (r_axis) begin
                    n_state = S_STEP;
                end else begin
                    n_axis  = 1'b1;
                    n_state = S_PREP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        if (o_cmd.load) begin
            n_ov = 1'b1;
        end else if (i_out_ready) begin
            n_ov = 1'b0;
        end
    end

    assign o_out_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_ov    <= n_ov;
        end
    end

endmodule

// ===== hdl/jasr_dp.sv =====
module jasr_dp #(
    parameter int P_AXIS_FULL_SCALE = jasr_pkg::AXIS_FULL_SCALE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [jasr_pkg::W_CFG_IDX-1:0]    i_cfg_idx,
    input  logic [jasr_pkg::W_CFG_DATA-1:0]   i_cfg_data,
    input  logic                              i_new_knot,
    input  logic                              i_connected,
    input  logic signed [15:0]                i_angle_axis,
    input  logic signed [15:0]                i_slide_axis,
    input  logic [7:0]                        i_phase_frac,
    input  jasr_pkg::t_cmd                    i_cmd,
    output jasr_pkg::t_sts                    o_sts,
    output logic signed [21:0]                o_angle_ref,
    output logic signed [18:0]                o_slide_ref,
    output logic signed [22:0]                o_angle_step,
    output logic signed [18:0]                o_slide_step
);

    localparam logic signed [24:0] DEN_RAW  = 25'(P_AXIS_FULL_SCALE);
    localparam logic signed [24:0] DEN_FULL = 25'(P_AXIS_FULL_SCALE * 256);

    // configuration
    logic               r_raw;
    logic [20:0]        r_al;
    logic signed [18:0] r_sn, r_spl, r_sph;
    logic [17:0]        r_asl;
    logic [13:0]        r_ssl;
    logic [14:0]        r_db;

    // knot state
    logic signed [23:0] r_aavg, r_savg;
    logic signed [21:0] r_ka;
    logic signed [18:0] r_ks;
    logic signed [22:0] r_kas;
    logic signed [18:0] r_kss;

    // latched request
    logic               r_conn;
    logic signed [15:0] r_ax, r_sx;
    logic [7:0]         r_ph;

    // scaling unit
    logic [23:0]        r_num;
    logic signed [24:0] r_den;
    logic               r_neg, r_full;
    logic [20:0]        r_m;
    logic [23:0]        r_rem;
    logic [20:0]        r_quo;
    logic [4:0]         r_cnt;
    logic signed [21:0] r_da, r_ds;

    // result register
    logic signed [21:0] r_oa;
    logic signed [18:0] r_os;
    logic signed [22:0] r_oas;
    logic signed [18:0] r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw <= 1'b0;
            r_al  <= jasr_pkg::RST_ANGLE_LIMIT;
            r_sn  <= jasr_pkg::RST_SLIDE_NEUTRAL;
            r_spl <= jasr_pkg::RST_SLIDE_PULL_LIMIT;
            r_sph <= jasr_pkg::RST_SLIDE_PUSH_LIMIT;
            r_asl <= jasr_pkg::RST_ANGLE_STEP_LIMIT;
            r_ssl <= jasr_pkg::RST_SLIDE_STEP_LIMIT;
            r_db  <= jasr_pkg::RST_DEAD_BAND;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jasr_pkg::REG_RAW_MODE:         r_raw <= i_cfg_data[0];
                jasr_pkg::REG_ANGLE_LIMIT:      r_al  <= i_cfg_data[20:0];
                jasr_pkg::REG_SLIDE_NEUTRAL:    r_sn  <= $signed(i_cfg_data[18:0]);
                jasr_pkg::REG_SLIDE_PULL_LIMIT: r_spl <= $signed(i_cfg_data[18:0]);
                jasr_pkg::REG_SLIDE_PUSH_LIMIT: r_sph <= $signed(i_cfg_data[18:0]);
                jasr_pkg::REG_ANGLE_STEP_LIMIT: r_asl <= i_cfg_data[17:0];
                jasr_pkg::REG_SLIDE_STEP_LIMIT: r_ssl <= i_cfg_data[13:0];
                jasr_pkg::REG_DEAD_BAND:        r_db  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // axis preparation
    logic signed [15:0] c_ax;
    logic signed [16:0] c_ax17;
    logic [16:0]        c_axmag;
    logic signed [23:0] c_avg;
    logic [23:0]        c_avgmag;
    logic [22:0]        c_d;
    logic signed [24:0] c_den_n, c_den;
    logic [23:0]        c_num_n, c_num;
    logic signed [19:0] c_span;
    logic [19:0]        c_spanmag;

    assign c_ax      = i_cmd.axis ? r_sx : r_ax;
    assign c_ax17    = 17'(c_ax);
    assign c_axmag   = c_ax[15] ? 17'(-c_ax17) : 17'(c_ax17);
    assign c_avg     = i_cmd.axis ? r_savg : r_aavg;
    assign c_avgmag  = c_avg[23] ? 24'(-c_avg) : 24'(c_avg);
    assign c_d       = {r_db, 8'd0};
    assign c_den_n   = DEN_FULL - $signed({2'b00, c_d});
    assign c_num_n   = (c_avgmag <= {1'b0, c_d}) ? 24'd0 : c_avgmag - {1'b0, c_d};
    assign c_num     = r_raw ? {7'd0, c_axmag} : c_num_n;
    assign c_den     = r_raw ? DEN_RAW : c_den_n;
    assign c_span    = 20'(r_sph) - 20'(r_sn);
    assign c_spanmag = c_span[19] ? 20'(-c_span) : 20'(c_span);

    // product plus half divisor, then restoring divide one quotient bit a cycle
    logic [43:0] c_mul;
    logic [44:0] c_prod;
    logic [24:0] c_t, c_dv;
    logic        c_ge;

    assign c_mul  = r_num[22:0] * r_m;
    assign c_prod = 45'(c_mul) + 45'(r_den[23:1]);
    assign c_t    = {r_rem, r_quo[20]};
    assign c_dv   = {1'b0, r_den[23:0]};
    assign c_ge   = c_t >= c_dv;

    // signed target
    logic [20:0]        c_k;
    logic               c_kneg;
    logic signed [21:0] c_ks;

    assign c_k    = r_full ? r_m : r_quo;
    assign c_kneg = i_cmd.axis ? (c_span[19] != r_neg) : r_neg;
    assign c_ks   = c_kneg ? -$signed({1'b0, c_k}) : $signed({1'b0, c_k});

    // averaging
    logic signed [24:0] c_asum, c_ssum;
    assign c_asum = 25'($signed({r_ax, 8'd0})) + 25'(r_aavg);
    assign c_ssum = 25'($signed({r_sx, 8'd0})) + 25'(r_savg);

    // step and knot update
    logic signed [23:0] c_ca, c_al, c_ka1, c_ka2;
    logic signed [19:0] c_cs, c_ks1, c_ks2;
    logic signed [24:0] c_sa, c_alim, c_sa1;
    logic signed [22:0] c_sa2;
    logic signed [22:0] c_ss, c_slim, c_ss1;
    logic signed [18:0] c_ss2;

    assign c_ca = 24'(r_ka) + 24'(r_kas);
    assign c_cs = 20'(r_ks) + 20'(r_kss);
    assign c_sa = 25'(r_da) - 25'(c_ca);
    assign c_ss = 23'(r_ds) - 23'(c_cs);
    assign c_alim = $signed({7'd0, r_asl});
    assign c_slim = $signed({9'd0, r_ssl});

    always_comb begin
        c_sa1 = c_sa;
        if (!r_raw) begin
            if (c_sa1 < -c_alim) c_sa1 = -c_alim;
            if (c_sa1 > c_alim)  c_sa1 = c_alim;
        end
        if (c_sa1 > 25'sd4194303)       c_sa2 = 23'sd4194303;
        else if (c_sa1 < -25'sd4194304) c_sa2 = -23'sd4194304;
        else                            c_sa2 = 23'(c_sa1);

        c_ss1 = c_ss;
        if (!r_raw) begin
            if (c_ss1 < -c_slim) c_ss1 = -c_slim;
            if (c_ss1 > c_slim)  c_ss1 = c_slim;
        end
        if (c_ss1 > 23'sd262143)       c_ss2 = 19'sd262143;
        else if (c_ss1 < -23'sd262144) c_ss2 = -19'sd262144;
        else                           c_ss2 = 19'(c_ss1);
    end

    assign c_al  = $signed({3'd0, r_al});
    assign c_ka1 = (c_ca < -c_al) ? -c_al : c_ca;
    assign c_ka2 = (c_ka1 > c_al) ? c_al : c_ka1;
    assign c_ks1 = (c_cs < 20'(r_spl)) ? 20'(r_spl) : c_cs;
    assign c_ks2 = (c_ks1 > 20'(r_sph)) ? 20'(r_sph) : c_ks1;

    // interpolation within the knot
    logic signed [30:0] c_pa;
    logic [30:0]        c_pam;
    logic [22:0]        c_ma;
    logic signed [24:0] c_ra;
    logic signed [21:0] c_ras;
    logic signed [26:0] c_ps;
    logic [26:0]        c_psm;
    logic [18:0]        c_ms;
    logic signed [20:0] c_rs;
    logic signed [18:0] c_rss;

    assign c_pa  = 31'(r_kas) * 31'($signed({1'b0, r_ph}));
    assign c_pam = c_pa[30] ? 31'(-c_pa) : 31'(c_pa);
    assign c_ma  = 23'((c_pam + 31'd128) >> 8);
    assign c_ra  = 25'(r_ka) + (c_pa[30] ? -$signed({2'b00, c_ma}) : $signed({2'b00, c_ma}));
    assign c_ras = (c_ra > 25'sd2097151) ? 22'sd2097151 :
                   (c_ra < -25'sd2097152) ? -22'sd2097152 : 22'(c_ra);

    assign c_ps  = 27'(r_kss) * 27'($signed({1'b0, r_ph}));
    assign c_psm = c_ps[26] ? 27'(-c_ps) : 27'(c_ps);
    assign c_ms  = 19'((c_psm + 27'd128) >> 8);
    assign c_rs  = 21'(r_ks) + (c_ps[26] ? -$signed({2'b00, c_ms}) : $signed({2'b00, c_ms}));
    assign c_rss = (c_rs > 21'sd262143) ? 19'sd262143 :
                   (c_rs < -21'sd262144) ? -19'sd262144 : 19'(c_rs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aavg <= '0;
            r_savg <= '0;
            r_ka   <= '0;
            r_ks   <= jasr_pkg::RST_SLIDE_NEUTRAL;
            r_kas  <= '0;
            r_kss  <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.avg && r_conn && !r_raw) begin
                r_aavg <= c_asum[24:1];
                r_savg <= c_ssum[24:1];
            end
            if (i_cmd.mul) begin
                r_cnt <= 5'(jasr_pkg::DIV_STEPS);
            end else if (i_cmd.div) begin
                r_cnt <= r_cnt - 5'd1;
            end
            if (i_cmd.step) begin
                r_kas <= c_sa2;
                r_kss <= c_ss2;
                r_ka  <= 22'(c_ka2);
                r_ks  <= 19'(c_ks2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_conn <= i_connected;
            r_ax   <= i_angle_axis;
            r_sx   <= i_slide_axis;
            r_ph   <= i_phase_frac;
        end
        if (i_cmd.avg) begin
            r_da <= '0;
            r_ds <= 22'(r_sn);
        end
        if (i_cmd.prep) begin
            r_num  <= c_num;
            r_den  <= c_den;
            r_neg  <= r_raw ? c_ax[15] : c_avg[23];
            r_m    <= i_cmd.axis ? 21'(c_spanmag) : r_al;
            r_full <= (c_den <= 25'sd0) || ($signed({1'b0, c_num}) >= c_den);
        end
        if (i_cmd.mul) begin
            r_rem <= c_prod[44:21];
            r_quo <= c_prod[20:0];
        end else if (i_cmd.div) begin
            r_rem <= c_ge ? 24'(c_t - c_dv) : c_t[23:0];
            r_quo <= {r_quo[19:0], c_ge};
        end
        if (i_cmd.tgt) begin
            if (i_cmd.axis) r_ds <= 22'(r_sn) + c_ks;
            else            r_da <= c_ks;
        end
        if (i_cmd.load) begin
            r_oa  <= c_ras;
            r_os  <= c_rss;
            r_oas <= r_kas;
            r_oss <= r_kss;
        end
    end

    assign o_sts.new_knot  = i_new_knot;
    assign o_sts.connected = r_conn;
    assign o_sts.div_done  = (r_cnt == 5'd0);

    assign o_angle_ref  = r_oa;
    assign o_slide_ref  = r_os;
    assign o_angle_step = r_oas;
    assign o_slide_step = r_oss;

endmodule

// ===== hdl/joystick_axis_slew_reference.sv =====
// a request without a new knot goes from acceptance straight to the output state
// a connected new knot runs two scaling divides of 21 steps each, one per axis,
// on one shared restoring divider, plus averaging, multiply, target and step states
// a new knot while disconnected skips scaling; one request is in work at a time
// reset (synchronous, active low) loads register defaults, zero averages and steps,
// and the slide knot at its neutral value
module joystick_axis_slew_reference #(
    parameter int P_AXIS_FULL_SCALE = jasr_pkg::AXIS_FULL_SCALE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [jasr_pkg::W_CFG_IDX-1:0]  i_cfg_idx,
    input  logic [jasr_pkg::W_CFG_DATA-1:0] i_cfg_data,
    jasr_in_if.sink                         i_in,
    jasr_out_if.source                      o_out
);

    // command and status between sequencer and datapath
    jasr_pkg::t_cmd cmd;
    jasr_pkg::t_sts sts;

    // sequencer: accept, average, scale each axis, step, present result
    jasr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath: registers, knot state, shared multiply and divide, interpolation
    jasr_dp #(
        .P_AXIS_FULL_SCALE (P_AXIS_FULL_SCALE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_new_knot   (i_in.new_knot),
        .i_connected  (i_in.connected),
        .i_angle_axis (i_in.angle_axis),
        .i_slide_axis (i_in.slide_axis),
        .i_phase_frac (i_in.phase_frac),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_angle_ref  (o_out.angle_ref),
        .o_slide_ref  (o_out.slide_ref),
        .o_angle_step (o_out.angle_step),
        .o_slide_step (o_out.slide_step)
    );

endmodule
